>>> rtl/linear_probe_hash_table_core_assert.svh
// assertion macros for the hash table core checks
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH

// same-cycle implication under reset
`define LPHT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under reset
`define LPHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/lpht_pkg.sv
// types, codes and constants shared by the hash table core files
package lpht_pkg;

	localparam int TABLE_SIZE_DEF = 16;
	localparam int KEY_W          = 31;
	localparam int CNT_W          = 5;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_MISS = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	localparam logic [1:0] TAG_EMPTY = 2'd0;
	localparam logic [1:0] TAG_TOMB  = 2'd1;
	localparam logic [1:0] TAG_LIVE  = 2'd2;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [CNT_W-1:0] probe_count;
	} rsp_t;

	typedef struct packed {
		logic [1:0]       tag;
		logic [KEY_W-1:0] key;
	} slot_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_ADDR,
		ST_PROBE
	} state_t;

endpackage

>>> rtl/linear_probe_hash_table_core.sv
// linear probing hash table with tombstones, slots held in one synchronous memory
//
// a command (insert, search or remove of a key) is taken when start is high and
// busy is low. the block then works on it alone: it multiplies the key by a
// constant reciprocal of TABLE_SIZE, then forms the home slot (key modulo
// TABLE_SIZE) from the low quotient bits and issues the first slot read, and the
// probe reads one slot a cycle from the slot memory, wrapping round, for k slots
// with 1 <= k <= TABLE_SIZE. insert and remove write the slot back in their last
// probe cycle.
// busy falls in the cycle the result is shown, so a new command may follow at once.
// the result (status, probe_count) is on the result port for one cycle with
// done high; the receiver cannot stall and must take it then.
// after reset the block clears every slot to empty, one slot a cycle, and holds
// busy high until every slot is cleared, before the first command is taken.
module linear_probe_hash_table_core #(
	parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  lpht_pkg::req_t request,
	output logic         done,
	output lpht_pkg::rsp_t result
);
	import lpht_pkg::*;

	localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam logic [AW-1:0] TS_TOP = AW'(TABLE_SIZE - 1);
	localparam logic [AW-1:0] TS_LO  = AW'(TABLE_SIZE);

	// quotient by reciprocal: ceil(2^(KEY_W+AW) / TABLE_SIZE), exact for every key
	localparam int SHIFT = KEY_W + AW;
	localparam longint unsigned MAGIC_L =
		((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
	localparam logic [KEY_W:0] MAGIC = (KEY_W+1)'(MAGIC_L);

	state_t state_q, state_d;

	slot_t mem [TABLE_SIZE];
	slot_t rd_q;

	logic [1:0]           op_q;
	logic [KEY_W-1:0]     key_q;
	logic [2*KEY_W:0]     prod;
	logic [AW-1:0]        quot_q;
	logic [AW-1:0]        home;
	logic [AW-1:0]        pos_q, pos_nxt;
	logic [AW-1:0]        lap_q;
	logic [AW-1:0]        clr_cnt_q;
	logic [CNT_W-1:0]     count_q, count_nx, cnt_inc;
	logic                 done_q;
	rsp_t                 result_q;

	logic       mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	slot_t      mem_wdata;
	logic       finish, advance, last_lap, hit;
	logic [1:0] status_nx;

	// remainder is below 2^AW, so only the low bits of the quotient matter
	assign prod = (2*KEY_W+1)'(key_q) * (2*KEY_W+1)'(MAGIC);
	assign home = key_q[AW-1:0] - AW'(quot_q * TS_LO);

	assign pos_nxt  = (pos_q == TS_TOP) ? '0 : pos_q + 1'b1;
	assign cnt_inc  = (count_q == CNT_MAX) ? count_q : count_q + 1'b1;
	assign last_lap = (lap_q == TS_TOP);
	assign hit      = (rd_q.tag == TAG_LIVE) && (rd_q.key == key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = '{tag: TAG_LIVE, key: key_q};
		mem_raddr = pos_q;
		finish    = 1'b0;
		advance   = 1'b0;
		status_nx = STATUS_MISS;
		count_nx  = count_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = '{tag: TAG_EMPTY, key: '0};
				if (clr_cnt_q == TS_TOP) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_MOD;
				end
			end
			ST_MOD: begin
				state_d = ST_ADDR;
			end
			ST_ADDR: begin
				mem_raddr = home;
				state_d   = ST_PROBE;
			end
			ST_PROBE: begin
				unique case (op_q)
					OP_INSERT: begin
						if (rd_q.tag != TAG_LIVE) begin
							mem_we    = 1'b1;
							finish    = 1'b1;
							status_nx = STATUS_OK;
						end else begin
							count_nx = cnt_inc;
							if (last_lap) begin
								finish    = 1'b1;
								status_nx = STATUS_FULL;
							end else begin
								advance = 1'b1;
							end
						end
					end
					OP_SEARCH: begin
						if (rd_q.tag == TAG_EMPTY) begin
							finish = 1'b1;
						end else begin
							if (rd_q.tag == TAG_LIVE) begin
								count_nx = cnt_inc;
							end
							if (hit) begin
								finish    = 1'b1;
								status_nx = STATUS_OK;
							end else if (last_lap) begin
								finish = 1'b1;
							end else begin
								advance = 1'b1;
							end
						end
					end
					OP_REMOVE: begin
						if (rd_q.tag == TAG_EMPTY) begin
							finish = 1'b1;
						end else if (hit) begin
							mem_we    = 1'b1;
							mem_wdata = '{tag: TAG_TOMB, key: key_q};
							finish    = 1'b1;
							status_nx = STATUS_OK;
						end else if (last_lap) begin
							finish = 1'b1;
						end else begin
							advance = 1'b1;
						end
					end
					default: begin
						finish = 1'b1;
					end
				endcase
				if (advance) begin
					mem_raddr = pos_nxt;
				end
				if (finish) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// slot memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= 1'b0;
			clr_cnt_q <= '0;
		end else begin
			done_q <= finish;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			op_q     <= request.opcode;
			key_q    <= request.key;
			count_q  <= '0;
			lap_q    <= '0;
		end
		if (state_q == ST_MOD) begin
			quot_q <= prod[SHIFT +: AW];
		end
		if (state_q == ST_ADDR) begin
			pos_q <= home;
		end
		if (advance) begin
			pos_q   <= pos_nxt;
			lap_q   <= lap_q + 1'b1;
			count_q <= count_nx;
		end
		if (finish) begin
			result_q <= '{status: status_nx, probe_count: count_nx};
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

>>> rtl/lpht_checker.sv
// port-level checks for the hash table core, bound into the core module
`include "linear_probe_hash_table_core_assert.svh"

module lpht_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input lpht_pkg::req_t request,
	input logic           done,
	input lpht_pkg::rsp_t result
);
	import lpht_pkg::*;

	logic accept;
	assign accept = start && !busy;

	`LPHT_ASSERT_SAME(a_done_idle, clk, arst_n, done, !busy, "result shown while busy")
	`LPHT_ASSERT_NEXT(a_busy_after, clk, arst_n, accept, busy, "busy not raised after transfer")
	`LPHT_ASSERT_NEXT(a_no_early, clk, arst_n, accept, !done, "result too soon after transfer")
	`LPHT_ASSERT_NEXT(a_one_strobe, clk, arst_n, done, !done, "result strobe longer than a cycle")

endmodule

bind linear_probe_hash_table_core lpht_checker u_lpht_checker (.*);

>>> dv/tb_linear_probe_hash_table_core.sv
// self-checking testbench for the linear probing hash table core: directed and random commands
module tb_linear_probe_hash_table_core;
	import lpht_pkg::*;

	localparam int SLOTS         = TABLE_SIZE_DEF;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS  = 450;
	localparam int BATCH         = 30;
	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 2 * SLOTS + 10;

	class slot_mirror;
		logic [1:0]       tag [SLOTS];
		logic [KEY_W-1:0] held_key [SLOTS];
		rsp_t             pending_results [$];
		int unsigned      failures;

		function new();
			foreach (tag[i]) begin
				tag[i] = TAG_EMPTY;
				held_key[i] = '0;
			end
			failures = 0;
		endfunction

		function void take_command(req_t cmd);
			int unsigned pos;
			int unsigned count;
			rsp_t want;
			pos = cmd.key % SLOTS;
			count = 0;
			want.status = STATUS_MISS;
			case (cmd.opcode)
				OP_INSERT: begin
					want.status = STATUS_FULL;
					for (int n = 0; n < SLOTS; n++) begin
						if (tag[pos] != TAG_LIVE) begin
							tag[pos] = TAG_LIVE;
							held_key[pos] = cmd.key;
							want.status = STATUS_OK;
							break;
						end
						count++;
						pos = (pos + 1) % SLOTS;
					end
				end
				OP_SEARCH: begin
					for (int n = 0; n < SLOTS; n++) begin
						if (tag[pos] == TAG_EMPTY)
							break;
						if (tag[pos] == TAG_LIVE) begin
							count++;
							if (held_key[pos] == cmd.key) begin
								want.status = STATUS_OK;
								break;
							end
						end
						pos = (pos + 1) % SLOTS;
					end
				end
				OP_REMOVE: begin
					for (int n = 0; n < SLOTS; n++) begin
						if (tag[pos] == TAG_EMPTY)
							break;
						if (tag[pos] == TAG_LIVE && held_key[pos] == cmd.key) begin
							tag[pos] = TAG_TOMB;
							want.status = STATUS_OK;
							break;
						end
						pos = (pos + 1) % SLOTS;
					end
				end
				default: ;
			endcase
			want.probe_count = (count > CNT_MAX) ? CNT_MAX : CNT_W'(count);
			pending_results.push_back(want);
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (pending_results.size() == 0) begin
				$error("result with nothing outstanding: status %0d probe_count %0d",
					got.status, got.probe_count);
				failures++;
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				failures++;
			end
			if (got.probe_count !== want.probe_count) begin
				$error("probe_count: expected %0d, actual %0d",
					want.probe_count, got.probe_count);
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t request;
	rsp_t result;

	slot_mirror mirror = new();
	int unsigned quiet_cycles = 0;

	logic [KEY_W-1:0] key_pool [$];
	logic [KEY_W-1:0] pick_key;
	logic [1:0]       pick_op;
	int unsigned      roll;
	int unsigned      fill_pct;
	int unsigned      pool_idx;
	bit               steady;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	linear_probe_hash_table_core #(
		.TABLE_SIZE(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				mirror.check_result(result);
			if (start && !busy)
				mirror.take_command(request);
			if (done || (start && !busy))
				quiet_cycles <= 0;
			else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("linear_probe_hash_table_core verification failed");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [KEY_W-1:0] fresh_key();
		logic [KEY_W-1:0] k;
		k = KEY_W'($urandom);
		// crowd keys around the wrap point so probes run long
		if ($urandom_range(0, 3) != 0)
			k[3:0] = 4'(13 + $urandom_range(0, 3));
		return k;
	endfunction

	function automatic int unsigned random_gap(bit no_gaps);
		int unsigned r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 9);
		if (r < 6)
			return 0;
		if (r < 9)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	task automatic send(logic [1:0] op, logic [KEY_W-1:0] k, int unsigned gap);
		req_t cmd;
		cmd.opcode = op;
		cmd.key = k;
		start <= 1'b1;
		request <= cmd;
		do
			@(posedge clk);
		while (busy);
		if (gap != 0) begin
			start <= 1'b0;
			request <= {2'($urandom), KEY_W'($urandom)};
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		do
			@(negedge clk);
		while (mirror.pending_results.size() != 0);
		@(posedge clk);
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		request <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// empty table, unused code
		send(OP_SEARCH, '0, 0);
		send(OP_REMOVE, '1, 2);
		send(OP_UNUSED, 31'h2AAA_AAAA, 0);
		// collisions and wrap-around
		send(OP_INSERT, '0, 0);
		send(OP_INSERT, '1, 0);
		send(OP_INSERT, 31'd16, 1);
		send(OP_INSERT, 31'd15, 0);
		send(OP_SEARCH, 31'd15, 0);
		// tombstone skipped by search, reused by insert
		send(OP_REMOVE, 31'd16, 0);
		send(OP_SEARCH, 31'd15, 3);
		send(OP_INSERT, 31'd32, 0);
		// duplicate key
		send(OP_INSERT, '0, 0);
		// fill the table, then overflow it
		for (int i = 0; i < SLOTS - 5; i++)
			send(OP_INSERT, KEY_W'(i * 16 + 4), 0);
		send(OP_INSERT, 31'h5555_5555, 0);
		send(OP_SEARCH, 31'h4000_0007, 0);
		send(OP_REMOVE, '1, 0);
		send(OP_REMOVE, '1, 0);
		wait_for_results();

		for (int batch = 0; batch < RANDOM_ITEMS / BATCH; batch++) begin
			fill_pct = (batch % 3 == 0) ? 65 : $urandom_range(15, 45);
			steady = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < BATCH; i++) begin
				roll = $urandom_range(0, 99);
				pick_key = fresh_key();
				if (roll < 4)
					pick_op = OP_UNUSED;
				else if (roll < 4 + fill_pct) begin
					pick_op = OP_INSERT;
					if (key_pool.size() != 0 && $urandom_range(0, 7) == 0)
						pick_key = key_pool[$urandom_range(0, key_pool.size() - 1)];
					key_pool.push_back(pick_key);
					if (key_pool.size() > 40)
						void'(key_pool.pop_front());
				end else begin
					pick_op = (roll < 4 + fill_pct + (96 - fill_pct) / 2) ?
						OP_SEARCH : OP_REMOVE;
					if (key_pool.size() != 0 && $urandom_range(0, 3) != 0) begin
						pool_idx = $urandom_range(0, key_pool.size() - 1);
						pick_key = key_pool[pool_idx];
						if (pick_op == OP_REMOVE)
							key_pool.delete(pool_idx);
					end
				end
				send(pick_op, pick_key, random_gap(steady));
			end
			if (batch % 4 == 3)
				wait_for_results();
		end

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mirror.failures == 0 && mirror.pending_results.size() == 0)
			$display("linear_probe_hash_table_core verification clean");
		else
			$display("linear_probe_hash_table_core verification failed");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/lpht_pkg.sv
rtl/linear_probe_hash_table_core.sv
rtl/lpht_checker.sv
dv/tb_linear_probe_hash_table_core.sv
